[rtl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXT     = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } wsd_phase_type;

   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_EMPTY    = 3'd1,
      KIND_CLOSE    = 3'd2,
      KIND_NOMASK   = 3'd3,
      KIND_OVERSIZE = 3'd4
   } wsd_kind_type;

   localparam logic [3:0] OPCODE_CLOSE  = 4'h8;
   localparam logic [6:0] LEN_CODE_16   = 7'd126;
   localparam logic [6:0] LEN_CODE_64   = 7'd127;
   localparam logic [3:0] EXT_BYTES_16  = 4'd2;
   localparam logic [3:0] EXT_BYTES_64  = 4'd8;
   localparam logic [3:0] KEY_BYTES     = 4'd4;

   localparam logic       CSR_REQUIRE_MASK = 1'b0;
   localparam logic       CSR_MAX_BYTES    = 1'b1;
   localparam logic [31:0] MAX_BYTES_RESET = 32'd65536;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      wsd_kind_type kind;
      logic [7:0]   raw_byte;
      logic [7:0]   key_byte;
      logic [3:0]   frame_opcode;
      logic [3:0]   message_opcode;
      logic         is_control;
      logic         frame_last;
      logic         message_last;
   } wsd_cmd_type;

endpackage

[rtl/wsd_req_if.sv]
// ----------------------------------------------------------------------------
// wsd_req_if
// Request channel: one received stream byte per request.
// ----------------------------------------------------------------------------
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/wsd_rsp_if.sv]
// ----------------------------------------------------------------------------
// wsd_rsp_if
// Result channel: at most one payload byte or event per request.
// ----------------------------------------------------------------------------
interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] result_kind;
   logic [7:0] data_byte;
   logic [3:0] frame_opcode;
   logic [3:0] message_opcode;
   logic       is_control;
   logic       frame_last;
   logic       message_last;

   modport source (output valid, output result_kind, output data_byte,
                   output frame_opcode, output message_opcode, output is_control,
                   output frame_last, output message_last, input ready);
   modport sink   (input valid, input result_kind, input data_byte,
                   input frame_opcode, input message_opcode, input is_control,
                   input frame_last, input message_last, output ready);
endinterface

[rtl/wsd_front.sv]
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: accepts stream bytes, tracks frame and message state,
// and pushes one command per result into the queue.
// ----------------------------------------------------------------------------
module wsd_front
   import wsd_pkg::*;
#(
   parameter int LENGTH_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   wsd_req_if.sink     req,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        q_full,
   output logic        q_push,
   output wsd_cmd_type q_cmd
);

   localparam int CmpW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

   wsd_phase_type            phase_ff, phase_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic                     fin_ff, fin_in;
   logic                     mask_ff, mask_in;
   logic [3:0]               op_ff, op_in;
   logic [3:0]               ffop_ff, ffop_in;
   logic [LENGTH_BITS-1:0]   rem_ff, rem_in;
   logic [31:0]              key_ff, key_in;
   logic [1:0]               mphase_ff, mphase_in;
   logic [31:0]              total_ff, total_in;
   logic                     halted_ff, halted_in;
   logic                     reqmask_ff;
   logic [31:0]              max_ff;

   logic                     accept, go;
   logic [7:0]               b;
   logic [6:0]               len7;
   logic                     hdr_close, nomask, code16, code64;
   logic                     mask_new, lk_go, data_frame, over;
   logic [LENGTH_BITS-1:0]   ext_len, len_new, sp_len, rem_dec;
   logic [31:0]              used, diff;
   logic [CmpW-1:0]          sum;
   logic                     sp_go, sp_empty, pay_last, frame_end;
   logic [7:0]               kb;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign go        = accept && !halted_ff;
   assign b         = req.rx_byte;
   assign len7      = b[6:0];

   always_comb begin
      hdr_close  = go && (phase_ff == PH_HDR0) && (b[3:0] == OPCODE_CLOSE);
      nomask     = go && (phase_ff == PH_HDR1) && reqmask_ff && !b[7];
      code16     = len7 == LEN_CODE_16;
      code64     = len7 == LEN_CODE_64;
      mask_new   = (phase_ff == PH_HDR1) ? b[7] : mask_ff;
      ext_len    = {rem_ff[LENGTH_BITS-9:0], b};
      lk_go      = go && (((phase_ff == PH_HDR1) && !nomask && !code16 && !code64) ||
                          ((phase_ff == PH_EXT) && (cnt_ff == 4'd1)));
      len_new    = (phase_ff == PH_HDR1) ? {{(LENGTH_BITS-7){1'b0}}, len7} : ext_len;
      data_frame = !op_ff[3];
      used       = data_frame ? total_ff : 32'd0;
      diff       = max_ff - used;
      over       = (used > max_ff) || (CmpW'(len_new) > CmpW'(diff));
      sum        = CmpW'(used) + CmpW'(len_new);
      sp_go      = (lk_go && !over && !mask_new) ||
                   (go && (phase_ff == PH_KEY) && (cnt_ff == 4'd1));
      sp_len     = (phase_ff == PH_KEY) ? rem_ff : len_new;
      sp_empty   = sp_len == '0;
      rem_dec    = rem_ff - 1'b1;
      pay_last   = rem_dec == '0;
      frame_end  = (sp_go && sp_empty) || (go && (phase_ff == PH_PAYLOAD) && pay_last);
      case (mphase_ff)
         2'd0:    kb = key_ff[31:24];
         2'd1:    kb = key_ff[23:16];
         2'd2:    kb = key_ff[15:8];
         default: kb = key_ff[7:0];
      endcase
      if (!mask_ff) begin
         kb = 8'd0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (go) begin
         case (phase_ff)
            PH_HDR0: phase_in = PH_HDR1;
            PH_HDR1: begin
               if (code16 || code64) begin
                  phase_in = PH_EXT;
               end
            end
            PH_EXT:     phase_in = PH_EXT;
            PH_KEY:     phase_in = PH_KEY;
            PH_PAYLOAD: phase_in = PH_PAYLOAD;
            default:    phase_in = PH_HDR0;
         endcase
         if (lk_go && !over && mask_new) begin
            phase_in = PH_KEY;
         end
         if (sp_go) begin
            phase_in = PH_PAYLOAD;
         end
         if (frame_end) begin
            phase_in = PH_HDR0;
         end
      end
   end

   always_comb begin
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      mask_in   = mask_ff;
      op_in     = op_ff;
      ffop_in   = ffop_ff;
      rem_in    = rem_ff;
      key_in    = key_ff;
      mphase_in = mphase_ff;
      total_in  = total_ff;
      halted_in = halted_ff;
      q_push    = 1'b0;
      q_cmd     = '0;
      if (go) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in    = b[7];
               op_in     = b[3:0];
               mphase_in = 2'd0;
               rem_in    = '0;
               if (!hdr_close && !b[3] && (b[3:0] != 4'd0)) begin
                  ffop_in  = b[3:0];
                  total_in = 32'd0;
               end
            end
            PH_HDR1: begin
               mask_in = b[7];
               if (code16) begin
                  cnt_in = EXT_BYTES_16;
               end else if (code64) begin
                  cnt_in = EXT_BYTES_64;
               end else begin
                  rem_in = len_new;
               end
            end
            PH_EXT: begin
               cnt_in = cnt_ff - 4'd1;
               rem_in = ext_len;
            end
            PH_KEY: begin
               cnt_in = cnt_ff - 4'd1;
               key_in = {key_ff[23:0], b};
            end
            PH_PAYLOAD: begin
               mphase_in = mphase_ff + 2'd1;
               rem_in    = rem_dec;
            end
            default: begin
               rem_in = rem_ff;
            end
         endcase
         if (lk_go && !over) begin
            if (data_frame) begin
               total_in = sum[31:0];
            end
            if (mask_new) begin
               cnt_in = KEY_BYTES;
            end
         end
         if (frame_end && data_frame && fin_ff) begin
            total_in = 32'd0;
         end
         if (hdr_close || nomask || (lk_go && over)) begin
            halted_in = 1'b1;
         end
      end

      q_cmd.frame_opcode   = op_in;
      q_cmd.message_opcode = ffop_in;
      q_cmd.is_control     = op_in[3];
      if (hdr_close) begin
         q_push     = 1'b1;
         q_cmd.kind = KIND_CLOSE;
      end else if (nomask) begin
         q_push     = 1'b1;
         q_cmd.kind = KIND_NOMASK;
      end else if (lk_go && over) begin
         q_push     = 1'b1;
         q_cmd.kind = KIND_OVERSIZE;
      end else if (sp_go && sp_empty) begin
         q_push     = 1'b1;
         q_cmd.kind = KIND_EMPTY;
         q_cmd.frame_last = 1'b1;
      end else if (go && (phase_ff == PH_PAYLOAD)) begin
         q_push           = 1'b1;
         q_cmd.kind       = KIND_DATA;
         q_cmd.raw_byte   = b;
         q_cmd.key_byte   = kb;
         q_cmd.frame_last = pay_last;
      end
      q_cmd.message_last = q_cmd.frame_last && fin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         cnt_ff     <= 4'd0;
         fin_ff     <= 1'b0;
         mask_ff    <= 1'b0;
         op_ff      <= 4'd0;
         ffop_ff    <= 4'd0;
         rem_ff     <= '0;
         key_ff     <= 32'd0;
         mphase_ff  <= 2'd0;
         total_ff   <= 32'd0;
         halted_ff  <= 1'b0;
         reqmask_ff <= 1'b1;
         max_ff     <= MAX_BYTES_RESET;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         fin_ff    <= fin_in;
         mask_ff   <= mask_in;
         op_ff     <= op_in;
         ffop_ff   <= ffop_in;
         rem_ff    <= rem_in;
         key_ff    <= key_in;
         mphase_ff <= mphase_in;
         total_ff  <= total_in;
         halted_ff <= halted_in;
         if (csr_we) begin
            case (csr_index)
               CSR_REQUIRE_MASK: reqmask_ff <= csr_wdata[0];
               CSR_MAX_BYTES:    max_ff     <= csr_wdata;
               default:          max_ff     <= max_ff;
            endcase
         end
      end
   end

endmodule

[rtl/wsd_queue.sv]
// ----------------------------------------------------------------------------
// wsd_queue
// Short command queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module wsd_queue
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  wsd_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output wsd_cmd_type head_cmd
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   wsd_cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wptr_ff, wptr_in;
   logic [PtrW-1:0]     rptr_ff, rptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign full      = count_ff == CntW'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_cmd  = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/wsd_back.sv]
// ----------------------------------------------------------------------------
// wsd_back
// Result stage: unmasks payload bytes and holds the result register.
// ----------------------------------------------------------------------------
module wsd_back
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  wsd_cmd_type q_cmd,
   output logic        q_pop,
   wsd_rsp_if.source   rsp
);

   logic        valid_ff, valid_in;
   wsd_cmd_type out_ff, out_in;

   assign q_pop = q_valid && (!valid_ff || rsp.ready);

   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      if (q_pop) begin
         valid_in        = 1'b1;
         out_in          = q_cmd;
         out_in.raw_byte = q_cmd.raw_byte ^ q_cmd.key_byte;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.result_kind    = out_ff.kind;
   assign rsp.data_byte      = out_ff.raw_byte;
   assign rsp.frame_opcode   = out_ff.frame_opcode;
   assign rsp.message_opcode = out_ff.message_opcode;
   assign rsp.is_control     = out_ff.is_control;
   assign rsp.frame_last     = out_ff.frame_last;
   assign rsp.message_last   = out_ff.message_last;

endmodule

[rtl/websocket_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Receive-side WebSocket frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one received stream byte per request. rsp_chan returns
//   at most one result per byte: an unmasked payload byte or an event
//   (empty frame end, close, missing mask, oversize message).
//   csr_we/csr_index/csr_wdata write require_mask (index 0) and
//   max_message_bytes (index 1); write them only while the block is idle.
//   Throughput is one byte per cycle while the queue is not full, set by
//   the header parser, which updates its state on every accepted byte.
//   An accepted byte's result passes through the command queue and then
//   the result register before it reaches rsp_chan.
//   When the receiver stalls, the 4-entry queue and the result register
//   absorb results; req_chan.ready drops once the queue is full.
//   After close or an error, bytes are still taken but dropped.
//   Reset clears the parser, the queue pointers and the result register's
//   valid flag and restores the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit
   import wsd_pkg::*;
#(
   parameter int LENGTH_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   wsd_req_if.sink     req_chan,
   wsd_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   logic        q_full, q_push, q_pop, q_valid;
   wsd_cmd_type push_cmd, head_cmd;

   wsd_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   wsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_cmd  (head_cmd)
   );

   wsd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (head_cmd),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule
